/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define AST_HOLD(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold in the cycle after ante
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// cons must hold in the same cycle as ante
`define AST_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/bma_pkg.sv */
// ----------------------------------------------------------------------------
// bma_pkg
// Shared widths, codes and controller/datapath interface types for the
// bit map allocator.
// ----------------------------------------------------------------------------
package bma_pkg;

  localparam int WORD_BITS        = 64;
  localparam int DEF_MAX_MAP_BITS = 1024;

  localparam int MODE_W   = 3;
  localparam int INDEX_W  = 10;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  localparam logic [COUNT_W-1:0] BITS_IN_USE_RST = 11'd1024;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE         = 3'd0,
    MODE_TEST_SET      = 3'd1,
    MODE_TEST_CLEAR    = 3'd2,
    MODE_FIND_ONE      = 3'd3,
    MODE_FIND_ONE_CLR  = 3'd4,
    MODE_FIND_ZERO     = 3'd5,
    MODE_FIND_ZERO_SET = 3'd6,
    MODE_FILL          = 3'd7
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_NONE  = 2'd2
  } status_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    CMD_NOP       = 4'd0,
    CMD_ACCEPT    = 4'd1,
    CMD_CFG       = 4'd2,
    CMD_CLEAR     = 4'd3,
    CMD_READ      = 4'd4,
    CMD_BIT       = 4'd5,
    CMD_SCAN      = 4'd6,
    CMD_FILL      = 4'd7,
    CMD_END_RANGE = 4'd8,
    CMD_END_EMPTY = 4'd9
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    finish;   // result is registered at this edge
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_bit;       // write / test request
    logic is_find;
    logic in_range;     // bit index below bits in use
    logic none_in_use;  // zero bits in use
    logic hit;          // scanned word has a candidate
    logic last_all;     // pointer at last word of the map
    logic last_used;    // pointer at last word holding used bits
  } dp_stat_t;

  // lowest set bit, binary search in six halving steps
  function automatic logic [5:0] ffs64(input logic [63:0] x);
    logic [63:0] v;
    logic [5:0]  pos;
    int          s;
    int          k;
    pos = 6'd0;
    v   = x;
    for (k = 0; k < 6; k++) begin
      s = 32 >> k;
      if ((v & ((64'd1 << s) - 64'd1)) == 64'd0) begin
        pos = pos | 6'(s);
        v   = v >> s;
      end
    end
    return pos;
  endfunction

endpackage

/* rtl/bma_ctrl.sv */
// ----------------------------------------------------------------------------
// bma_ctrl
// Sequencer for the allocator: clear pass, decode, bit access, word scan
// and fill sweep.
// ----------------------------------------------------------------------------
module bma_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  bma_pkg::dp_stat_t   stat,
  output bma_pkg::ctrl_cmd_t  cmd
);
  import bma_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_DECODE = 6'b000100,
    ST_BIT    = 6'b001000,
    ST_SCAN   = 6'b010000,
    ST_FILL   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign cfg_ready = (state_r == ST_IDLE) || (state_r == ST_CLEAR);
  assign busy      = (state_r != ST_IDLE) || cfg_valid;

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = CMD_NOP;
    cmd.finish = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        if (cfg_valid) begin
          cmd.op = CMD_CFG;
        end else begin
          cmd.op = CMD_CLEAR;
          if (stat.last_all) state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cfg_valid) begin
          cmd.op    = CMD_CFG;
          state_nxt = ST_CLEAR;
        end else if (start) begin
          cmd.op    = CMD_ACCEPT;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.is_bit) begin
          if (stat.in_range) begin
            cmd.op    = CMD_READ;
            state_nxt = ST_BIT;
          end else begin
            cmd.op     = CMD_END_RANGE;
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else if (stat.none_in_use) begin
          cmd.op     = CMD_END_EMPTY;
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (stat.is_find) begin
          cmd.op    = CMD_READ;
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_BIT: begin
        cmd.op     = CMD_BIT;
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.op = CMD_SCAN;
        if (stat.hit || stat.last_used) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_FILL: begin
        cmd.op = CMD_FILL;
        if (stat.last_used) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/bma_datapath.sv */
// ----------------------------------------------------------------------------
// bma_datapath
// Word memory, request and config registers, ones counter, word pointer
// and result registers of the allocator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bma_datapath #(
  parameter int MAX_MAP_BITS = bma_pkg::DEF_MAX_MAP_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bma_pkg::COUNT_W-1:0]   cfg_bits_in_use,
  input  logic [bma_pkg::MODE_W-1:0]    in_mode,
  input  logic [bma_pkg::INDEX_W-1:0]   in_bit_index,
  input  logic                          in_bit_value,
  input  bma_pkg::ctrl_cmd_t            cmd,
  output bma_pkg::dp_stat_t             stat,
  output logic                          out_valid,
  output logic [bma_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_old_value,
  output logic [bma_pkg::INDEX_W-1:0]   out_found_index,
  output logic [bma_pkg::COUNT_W-1:0]   out_count_ones,
  output logic [bma_pkg::COUNT_W-1:0]   out_count_zeros
);
  import bma_pkg::*;

  localparam int NUM_WORDS = (MAX_MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int EW        = (WW + 7 > COUNT_W + 1) ? WW + 7 : COUNT_W + 1;

  localparam logic [EW-1:0]  MAX_E    = EW'(MAX_MAP_BITS);
  localparam logic [WW-1:0]  LAST_ALL = WW'(NUM_WORDS - 1);

  // mask of used bits inside word w
  function automatic logic [63:0] vmask(input logic [WW-1:0] w, input logic [COUNT_W-1:0] n);
    logic [EW-1:0] base;
    logic [EW-1:0] nn;
    logic [EW-1:0] rem;
    base = EW'(w) << 6;
    nn   = EW'(n);
    rem  = nn - base;
    if (base >= nn) return 64'd0;
    if (rem >= EW'(WORD_BITS)) return '1;
    return (64'd1 << rem[5:0]) - 64'd1;
  endfunction

  logic [63:0] mem [NUM_WORDS];

  logic [COUNT_W-1:0] biu_r, biu_nxt;
  mode_t              mode_r, mode_nxt;
  logic [INDEX_W-1:0] idx_r, idx_nxt;
  logic               val_r, val_nxt;
  logic [WW-1:0]      ptr_r, ptr_nxt;
  logic [COUNT_W-1:0] ones_r, ones_nxt;
  logic [63:0]        rdata_r;

  logic               out_valid_r, out_valid_nxt;
  status_t            status_r, status_nxt;
  logic               old_r, old_nxt;
  logic [INDEX_W-1:0] found_r, found_nxt;
  logic [COUNT_W-1:0] cnt1_r, cnt1_nxt;
  logic [COUNT_W-1:0] cnt0_r, cnt0_nxt;

  logic               rd_en, wr_en;
  logic [WW-1:0]      rd_addr, wr_addr;
  logic [63:0]        wr_data;

  logic [COUNT_W-1:0] n_w;
  logic [EW-1:0]      nm1_w;
  logic [WW-1:0]      last_used_w;
  logic [EW-1:0]      idx_ext;
  logic [WW-1:0]      idx_word;
  logic [5:0]         bitpos;
  logic [63:0]        bm;
  logic               is_bit, is_find, want_one, modify;
  logic               old_bit, new_bit;
  logic [63:0]        mask_w, cand, fbm;
  logic               hit;
  logic [5:0]         fpos;
  logic [EW-1:0]      found_wide;

  // bits in use, clipped to the map size
  assign n_w         = (EW'(biu_r) > MAX_E) ? MAX_E[COUNT_W-1:0] : biu_r;
  assign nm1_w       = EW'(n_w) - EW'(1);
  assign last_used_w = nm1_w[WW+5:6];
  assign idx_ext     = EW'(idx_r);
  assign idx_word    = idx_ext[WW+5:6];
  assign bitpos      = idx_r[5:0];
  assign bm          = 64'd1 << bitpos;
  assign old_bit     = rdata_r[bitpos];

  always_comb begin
    is_bit   = 1'b0;
    is_find  = 1'b0;
    want_one = 1'b0;
    modify   = 1'b0;
    new_bit  = old_bit;
    case (mode_r)
      MODE_WRITE: begin
        is_bit  = 1'b1;
        new_bit = val_r;
      end
      MODE_TEST_SET: begin
        is_bit  = 1'b1;
        new_bit = 1'b1;
      end
      MODE_TEST_CLEAR: begin
        is_bit  = 1'b1;
        new_bit = 1'b0;
      end
      MODE_FIND_ONE: begin
        is_find  = 1'b1;
        want_one = 1'b1;
      end
      MODE_FIND_ONE_CLR: begin
        is_find  = 1'b1;
        want_one = 1'b1;
        modify   = 1'b1;
      end
      MODE_FIND_ZERO: begin
        is_find = 1'b1;
      end
      MODE_FIND_ZERO_SET: begin
        is_find = 1'b1;
        modify  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign mask_w     = vmask(ptr_r, n_w);
  assign cand       = (want_one ? rdata_r : ~rdata_r) & mask_w;
  assign hit        = |cand;
  assign fpos       = ffs64(cand);
  assign fbm        = 64'd1 << fpos;
  assign found_wide = (EW'(ptr_r) << 6) | EW'(fpos);

  assign stat.is_bit      = is_bit;
  assign stat.is_find     = is_find;
  assign stat.in_range    = {1'b0, idx_r} < n_w;
  assign stat.none_in_use = (n_w == '0);
  assign stat.hit         = hit;
  assign stat.last_all    = (ptr_r == LAST_ALL);
  assign stat.last_used   = (ptr_r == last_used_w);

  always_comb begin
    biu_nxt  = biu_r;
    mode_nxt = mode_r;
    idx_nxt  = idx_r;
    val_nxt  = val_r;
    ptr_nxt  = ptr_r;
    ones_nxt = ones_r;
    rd_en    = 1'b0;
    rd_addr  = ptr_r;
    wr_en    = 1'b0;
    wr_addr  = ptr_r;
    wr_data  = 64'd0;
    case (cmd.op)
      CMD_ACCEPT: begin
        mode_nxt = mode_t'(in_mode);
        idx_nxt  = in_bit_index;
        val_nxt  = in_bit_value;
        ptr_nxt  = '0;
      end
      CMD_CFG: begin
        biu_nxt  = cfg_bits_in_use;
        ones_nxt = '0;
        ptr_nxt  = '0;
      end
      CMD_CLEAR: begin
        wr_en   = 1'b1;
        ptr_nxt = ptr_r + WW'(1);
      end
      CMD_READ: begin
        rd_en   = 1'b1;
        rd_addr = is_bit ? idx_word : ptr_r;
      end
      CMD_BIT: begin
        wr_addr = idx_word;
        wr_data = new_bit ? (rdata_r | bm) : (rdata_r & ~bm);
        if (new_bit != old_bit) begin
          wr_en    = 1'b1;
          ones_nxt = new_bit ? ones_r + COUNT_W'(1) : ones_r - COUNT_W'(1);
        end
      end
      CMD_SCAN: begin
        // evaluate word at ptr, fetch the next one
        rd_en   = 1'b1;
        rd_addr = ptr_r + WW'(1);
        ptr_nxt = ptr_r + WW'(1);
        wr_data = want_one ? (rdata_r & ~fbm) : (rdata_r | fbm);
        if (hit && modify) begin
          wr_en    = 1'b1;
          ones_nxt = want_one ? ones_r - COUNT_W'(1) : ones_r + COUNT_W'(1);
        end
      end
      CMD_FILL: begin
        wr_en    = 1'b1;
        wr_data  = val_r ? mask_w : 64'd0;
        ptr_nxt  = ptr_r + WW'(1);
        ones_nxt = val_r ? n_w : '0;
      end
      CMD_END_EMPTY: begin
        if (!is_find) ones_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = cmd.finish;
    status_nxt    = STATUS_OK;
    old_nxt       = 1'b0;
    found_nxt     = '0;
    cnt1_nxt      = ones_nxt;
    cnt0_nxt      = n_w - ones_nxt;
    case (cmd.op)
      CMD_END_RANGE: status_nxt = STATUS_RANGE;
      CMD_END_EMPTY: status_nxt = is_find ? STATUS_NONE : STATUS_OK;
      CMD_BIT:       old_nxt    = old_bit;
      CMD_SCAN: begin
        if (hit) begin
          old_nxt   = want_one;
          found_nxt = found_wide[INDEX_W-1:0];
        end else begin
          status_nxt = STATUS_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      biu_r       <= BITS_IN_USE_RST;
      ptr_r       <= '0;
      ones_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      biu_r       <= biu_nxt;
      ptr_r       <= ptr_nxt;
      ones_r      <= ones_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    idx_r  <= idx_nxt;
    val_r  <= val_nxt;
    if (cmd.finish) begin
      status_r <= status_nxt;
      old_r    <= old_nxt;
      found_r  <= found_nxt;
      cnt1_r   <= cnt1_nxt;
      cnt0_r   <= cnt0_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_old_value   = old_r;
  assign out_found_index = found_r;
  assign out_count_ones  = cnt1_r;
  assign out_count_zeros = cnt0_r;

  `AST_HOLD(a_ones_bound, clk, rst_n, ones_r <= n_w, "ones count above bits in use")
  `AST_SAME(a_scan_ptr, clk, rst_n, cmd.op == CMD_SCAN, ptr_r <= last_used_w, "scan past used words")

endmodule

/* rtl/bitmap_allocator_unit.sv */
// ----------------------------------------------------------------------------
// bitmap_allocator_unit
// Bit map allocator: write/test bits, find lowest set or clear bit, fill.
// Write/test reads the addressed word and writes a changed bit back; out-of-range
//   and a find or fill with no bits in use end at decode; a find scans one 64-bit
//   word per cycle (bounded by the memory read port) up to a hit or the last used
//   word; a fill sweeps the used words. Next request is taken in the strobe cycle.
// Reset and every bits_in_use write run a clear pass over every word of the
//   word memory, busy high; results cannot be stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_allocator_unit #(
  parameter int MAX_MAP_BITS = bma_pkg::DEF_MAX_MAP_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic [bma_pkg::MODE_W-1:0]    in_mode,
  input  logic [bma_pkg::INDEX_W-1:0]   in_bit_index,
  input  logic                          in_bit_value,
  // result channel, one-cycle strobe
  output logic                          out_valid,
  output logic [bma_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_old_value,
  output logic [bma_pkg::INDEX_W-1:0]   out_found_index,
  output logic [bma_pkg::COUNT_W-1:0]   out_count_ones,
  output logic [bma_pkg::COUNT_W-1:0]   out_count_zeros,
  // bits_in_use register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bma_pkg::COUNT_W-1:0]   cfg_bits_in_use
);
  import bma_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: owns the state, decides each cycle's datapath operation
  bma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // word memory, counters and result registers
  bma_datapath #(
    .MAX_MAP_BITS (MAX_MAP_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_bits_in_use (cfg_bits_in_use),
    .in_mode         (in_mode),
    .in_bit_index    (in_bit_index),
    .in_bit_value    (in_bit_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_old_value   (out_old_value),
    .out_found_index (out_found_index),
    .out_count_ones  (out_count_ones),
    .out_count_zeros (out_count_zeros)
  );

  // a request is accepted in idle and ends no earlier than decode, so strobes never touch
  `AST_NEXT(a_out_pulse, clk, rst_n, out_valid, !out_valid, "result strobe held two cycles")
  // a taken request keeps the unit busy in the following cycle
  `AST_NEXT(a_busy_after_req, clk, rst_n, start && !busy, busy, "not busy after request")

endmodule
